/* hdl/rfs_pkg.sv */
package rfs_pkg;

   // frame length and last bit position
   localparam int PayloadBits = 48;
   localparam int BitIdxW     = $clog2(PayloadBits);

   localparam logic [BitIdxW-1:0] LastBit = BitIdxW'(PayloadBits - 1);

   typedef logic [PayloadBits-1:0] frame_type;

   // phase codes
   localparam logic [1:0] PhIdle = 2'd0;
   localparam logic [1:0] PhPre  = 2'd1;
   localparam logic [1:0] PhSync = 2'd2;
   localparam logic [1:0] PhBits = 2'd3;

   localparam logic [15:0] CodeOn  = 16'd13107;
   localparam logic [15:0] CodeOff = 16'd21299;

   // register map
   localparam logic RegRepeatCount   = 1'b0;
   localparam logic RegPreambleUnits = 1'b1;

   localparam logic [3:0] RepeatCountReset   = 4'd3;
   localparam logic [5:0] PreambleUnitsReset = 6'd31;

   typedef struct packed {
      logic       switch_on;
      logic [2:0] button;
      logic [2:0] channel;
      logic       kind;
   } item_type;

   typedef struct packed {
      logic accepted;
      logic busy_res;
      logic led_on;
      logic tx_level;
   } result_type;

   function automatic logic [31:0] button_code(input logic [3:0] dev);
      logic [31:0] code;
      unique case (dev)
         4'd0:  code = 32'd859124533;
         4'd1:  code = 32'd861090613;
         4'd2:  code = 32'd892547893;
         4'd3:  code = 32'd1395864373;
         4'd4:  code = 32'd859124563;
         4'd5:  code = 32'd861090643;
         4'd6:  code = 32'd892547923;
         4'd7:  code = 32'd1395864403;
         4'd8:  code = 32'd859125043;
         4'd9:  code = 32'd861091123;
         4'd10: code = 32'd892548403;
         4'd11: code = 32'd1395864883;
         4'd12: code = 32'd859132723;
         4'd13: code = 32'd861098803;
         4'd14: code = 32'd892556083;
         4'd15: code = 32'd1395872563;
         default: code = 32'd0;
      endcase
      return code;
   endfunction

endpackage

/* hdl/rfs_core.sv */
module rfs_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  rfs_pkg::item_type    item,
   input  logic [3:0]           repeat_count,
   input  logic [5:0]           preamble_units,
   output rfs_pkg::result_type  result
);

   logic [1:0]                  phase_ff, phase_in;
   logic [5:0]                  unit_count_ff, unit_count_in;
   logic [rfs_pkg::BitIdxW-1:0] bit_index_ff, bit_index_in;
   logic [3:0]                  repeats_left_ff, repeats_left_in;
   rfs_pkg::frame_type          frame_bits_ff, frame_bits_in;
   logic                        line_level_ff, line_level_in;
   logic                        lamp_ff, lamp_in;

   logic                        cmd_ok;
   logic [1:0]                  ch_idx, bt_idx;
   logic [15:0]                 onoff;
   logic [5:0]                  unit_next;
   logic [rfs_pkg::BitIdxW-1:0] bit_next;
   logic                        cur_bit;
   logic                        lvl, led;

   assign ch_idx    = 2'(item.channel - 3'd1);
   assign bt_idx    = 2'(item.button - 3'd1);
   assign onoff     = item.switch_on ? rfs_pkg::CodeOn : rfs_pkg::CodeOff;
   assign unit_next = unit_count_ff + 6'd1;
   assign bit_next  = bit_index_ff + rfs_pkg::BitIdxW'(1);
   assign cur_bit   = frame_bits_ff[bit_index_ff];
   assign cmd_ok    = (phase_ff == rfs_pkg::PhIdle) &&
                      (item.channel >= 3'd1) && (item.channel <= 3'd4) &&
                      (item.button >= 3'd1) && (item.button <= 3'd4);

   always_comb begin
      phase_in        = phase_ff;
      unit_count_in   = unit_count_ff;
      bit_index_in    = bit_index_ff;
      repeats_left_in = repeats_left_ff;
      frame_bits_in   = frame_bits_ff;
      line_level_in   = line_level_ff;
      lamp_in         = lamp_ff;
      lvl             = line_level_ff;
      led             = 1'b0;

      if (!item.kind) begin
         if (cmd_ok) begin
            frame_bits_in   = rfs_pkg::frame_type'({onoff,
                                 rfs_pkg::button_code({ch_idx, bt_idx})});
            repeats_left_in = (repeat_count == 4'd0) ? 4'd0 : repeat_count - 4'd1;
            phase_in        = rfs_pkg::PhPre;
            unit_count_in   = 6'd0;
            bit_index_in    = '0;
            line_level_in   = 1'b0;
            lamp_in         = 1'b1;
         end
         lvl = line_level_in;
         led = lamp_in;
      end else begin
         unique case (phase_ff)
            rfs_pkg::PhPre: begin
               lvl           = 1'b0;
               led           = 1'b1;
               unit_count_in = unit_next;
               // a zero preamble length ends after one unit
               if (unit_next >= preamble_units || unit_next == 6'd0) begin
                  phase_in      = rfs_pkg::PhSync;
                  unit_count_in = 6'd0;
                  line_level_in = 1'b1;
                  lamp_in       = 1'b0;
               end
            end
            rfs_pkg::PhSync: begin
               lvl           = 1'b1;
               phase_in      = rfs_pkg::PhBits;
               unit_count_in = 6'd0;
               bit_index_in  = '0;
               line_level_in = 1'b0;
            end
            rfs_pkg::PhBits: begin
               lvl           = bit_index_ff[0];
               unit_count_in = unit_next;
               line_level_in = bit_index_ff[0];
               if (unit_next >= (cur_bit ? 6'd3 : 6'd1)) begin
                  unit_count_in = 6'd0;
                  if (bit_index_ff >= rfs_pkg::LastBit) begin
                     bit_index_in = '0;
                     if (repeats_left_ff != 4'd0) begin
                        repeats_left_in = repeats_left_ff - 4'd1;
                        phase_in        = rfs_pkg::PhPre;
                        line_level_in   = 1'b0;
                        lamp_in         = 1'b1;
                     end else begin
                        phase_in = rfs_pkg::PhIdle;
                     end
                  end else begin
                     bit_index_in  = bit_next;
                     line_level_in = bit_next[0];
                  end
               end
            end
            default: begin
               lamp_in = 1'b0;
            end
         endcase
      end

      result.tx_level = lvl;
      result.led_on   = led;
      result.busy_res = (phase_in != rfs_pkg::PhIdle);
      result.accepted = !item.kind && cmd_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= rfs_pkg::PhIdle;
         unit_count_ff   <= 6'd0;
         bit_index_ff    <= '0;
         repeats_left_ff <= 4'd0;
         line_level_ff   <= 1'b1;
         lamp_ff         <= 1'b0;
      end else if (item_valid) begin
         phase_ff        <= phase_in;
         unit_count_ff   <= unit_count_in;
         bit_index_ff    <= bit_index_in;
         repeats_left_ff <= repeats_left_in;
         line_level_ff   <= line_level_in;
         lamp_ff         <= lamp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_valid) begin
         frame_bits_ff <= frame_bits_in;
      end
   end

endmodule

/* hdl/rf_socket_pulse_frame_sender.sv */
// channel   direction  fields
// req_      in         tuser: kind; tdata: channel, button, switch_on
// rsp_      out        tdata: tx_level, led_on, busy_res, accepted
// csr_      in/out     repeat_count at 0x0, preamble_units at 0x4
//
// one transaction per cycle on req_ while ready; its result shows in rsp_ the cycle after
// the sequencer state updates in the same edge that takes the transaction
// req_tready drops only while the result register is full and rsp_tready is low
// synchronous active-high reset: line high, lamp off, idle, result register empty
module rf_socket_pulse_frame_sender (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [2:0] channel, [5:3] button, [6] switch_on
   input  logic        req_tuser,   // [0] kind

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] tx_level, [1] led_on, [2] busy_res, [3] accepted

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [3:0]          repeat_count_ff;
   logic [5:0]          preamble_units_ff;
   logic                csr_write;
   logic                req_take;
   rfs_pkg::item_type   item;
   rfs_pkg::result_type result;
   rfs_pkg::result_type rsp_data_ff;
   logic                rsp_valid_ff;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         repeat_count_ff   <= rfs_pkg::RepeatCountReset;
         preamble_units_ff <= rfs_pkg::PreambleUnitsReset;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            rfs_pkg::RegRepeatCount:   repeat_count_ff   <= csr_pwdata[3:0];
            rfs_pkg::RegPreambleUnits: preamble_units_ff <= csr_pwdata[5:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         rfs_pkg::RegRepeatCount:   csr_prdata = {28'd0, repeat_count_ff};
         rfs_pkg::RegPreambleUnits: csr_prdata = {26'd0, preamble_units_ff};
         default:                   csr_prdata = 32'd0;
      endcase
   end

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_take   = req_tvalid && req_tready;

   assign item.kind      = req_tuser;
   assign item.channel   = req_tdata[2:0];
   assign item.button    = req_tdata[5:3];
   assign item.switch_on = req_tdata[6];

   rfs_core u_core (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (req_take),
      .item           (item),
      .repeat_count   (repeat_count_ff),
      .preamble_units (preamble_units_ff),
      .result         (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_data_ff};

endmodule

/* hdl/rfs_checker.sv */
module rfs_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   // result register empties on reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // a taken command starts the preamble at once
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3] |-> rsp_tdata[2] && !rsp_tdata[0] && rsp_tdata[1])
      else $error("accepted command without preamble start");

   a_lamp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |-> rsp_tdata[2])
      else $error("lamp lit while idle");

endmodule

bind rf_socket_pulse_frame_sender rfs_checker u_rfs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
